// File: rtl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

    localparam int CHAR_W  = 21;
    localparam int COUNT_W = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [1:0]        kind;
        logic              last;
    } t_out_item;

    // results produced by one accepted item, towards the output queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_push;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2,
        MODE_HEX   = 2'd3
    } t_mode;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_EOI   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CHAR_W-1:0] CH_APOS   = 21'h27;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_N      = 21'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 21'h72;
    localparam logic [CHAR_W-1:0] CH_U      = 21'h75;
    localparam logic [CHAR_W-1:0] CH_0      = 21'h30;
    localparam logic [CHAR_W-1:0] CH_7      = 21'h37;
    localparam logic [CHAR_W-1:0] CH_9      = 21'h39;
    localparam logic [CHAR_W-1:0] CH_LA     = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 21'h66;
    localparam logic [CHAR_W-1:0] CH_UA     = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UF     = 21'h46;
    localparam logic [CHAR_W-1:0] CODE_LF   = 21'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR   = 21'h0D;

endpackage

// File: rtl/sed_decode.sv
`timescale 1ns / 1ps

module sed_decode #(
    parameter int MAX_OCTAL_DIGITS = 3,
    parameter int MAX_HEX_DIGITS   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  sed_pkg::t_in_item i_item,
    output sed_pkg::t_push   o_push
);

    sed_pkg::t_mode                  r_mode,  n_mode;
    logic [sed_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [sed_pkg::CHAR_W-1:0]      r_value, n_value;

    logic [sed_pkg::CHAR_W-1:0] c;
    logic is_oct, is_dec, is_lhex, is_uhex, is_hex;
    logic [3:0] hex_val;
    logic oct_room, hex_room;

    // plain-text handling of a character (also the terminator of a numeric escape)
    logic              p_emit;
    sed_pkg::t_out_item p_res;
    sed_pkg::t_mode    p_mode;

    sed_pkg::t_out_item val_res;
    sed_pkg::t_push     push;

    assign c        = i_item.char_code;
    assign is_oct   = (c >= sed_pkg::CH_0) && (c <= sed_pkg::CH_7);
    assign is_dec   = (c >= sed_pkg::CH_0) && (c <= sed_pkg::CH_9);
    assign is_lhex  = (c >= sed_pkg::CH_LA) && (c <= sed_pkg::CH_LF_HEX);
    assign is_uhex  = (c >= sed_pkg::CH_UA) && (c <= sed_pkg::CH_UF);
    assign is_hex   = is_dec || is_lhex || is_uhex;
    // 'a' and 'A' both have low nibble 1
    assign hex_val  = is_dec ? c[3:0] : (c[3:0] + 4'd9);
    assign oct_room = r_count < sed_pkg::COUNT_W'(MAX_OCTAL_DIGITS);
    assign hex_room = r_count < sed_pkg::COUNT_W'(MAX_HEX_DIGITS);

    always_comb begin
        p_emit         = 1'b1;
        p_res.out_char = c;
        p_res.kind     = sed_pkg::KIND_CHAR;
        p_res.last     = 1'b1;
        p_mode         = sed_pkg::MODE_PLAIN;
        if (c == sed_pkg::CH_QUOTE) begin
            p_res.out_char = '0;
            p_res.kind     = sed_pkg::KIND_CLOSE;
        end else if (c == sed_pkg::CH_BSLASH) begin
            p_emit = 1'b0;
            p_mode = sed_pkg::MODE_ESC;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_value = r_value;

        val_res.out_char = r_value;
        val_res.kind     = sed_pkg::KIND_CHAR;
        val_res.last     = 1'b0;

        push.cnt           = 2'd0;
        push.res0.out_char = '0;
        push.res0.kind     = sed_pkg::KIND_CHAR;
        push.res0.last     = 1'b1;
        push.res1          = p_res;

        if (i_item.end_of_input) begin
            n_mode         = sed_pkg::MODE_PLAIN;
            n_count        = '0;
            n_value        = '0;
            push.cnt       = 2'd1;
            push.res0.kind = sed_pkg::KIND_EOI;
        end else begin
            case (r_mode)
                sed_pkg::MODE_PLAIN: begin
                    n_mode    = p_mode;
                    n_count   = '0;
                    n_value   = '0;
                    push.cnt  = {1'b0, p_emit};
                    push.res0 = p_res;
                end
                sed_pkg::MODE_ESC: begin
                    n_mode   = sed_pkg::MODE_PLAIN;
                    n_count  = '0;
                    n_value  = '0;
                    push.cnt = 2'd1;
                    if (c == sed_pkg::CH_N) begin
                        push.res0.out_char = sed_pkg::CODE_LF;
                    end else if (c == sed_pkg::CH_R) begin
                        push.res0.out_char = sed_pkg::CODE_CR;
                    end else if (c == sed_pkg::CH_BSLASH || c == sed_pkg::CH_QUOTE
                                 || c == sed_pkg::CH_APOS) begin
                        push.res0.out_char = c;
                    end else if (c == sed_pkg::CH_U) begin
                        n_mode   = sed_pkg::MODE_HEX;
                        push.cnt = 2'd0;
                    end else if (is_oct) begin
                        n_mode   = sed_pkg::MODE_OCT;
                        n_count  = sed_pkg::COUNT_W'(1);
                        n_value  = {{(sed_pkg::CHAR_W-3){1'b0}}, c[2:0]};
                        push.cnt = 2'd0;
                    end else begin
                        push.res0.kind = sed_pkg::KIND_BAD;
                    end
                end
                sed_pkg::MODE_OCT: begin
                    if (is_oct && oct_room) begin
                        n_value = {r_value[sed_pkg::CHAR_W-4:0], c[2:0]};
                        n_count = r_count + 1'b1;
                    end else begin
                        n_mode    = p_mode;
                        n_count   = '0;
                        n_value   = '0;
                        push.res0 = val_res;
                        push.res0.last = !p_emit;
                        push.cnt  = p_emit ? 2'd2 : 2'd1;
                    end
                end
                sed_pkg::MODE_HEX: begin
                    if (is_hex && hex_room) begin
                        n_value = {r_value[sed_pkg::CHAR_W-5:0], hex_val};
                        n_count = r_count + 1'b1;
                    end else if (r_count == '0) begin
                        n_mode         = sed_pkg::MODE_PLAIN;
                        n_value        = '0;
                        push.cnt       = 2'd1;
                        push.res0.kind = sed_pkg::KIND_BAD;
                    end else begin
                        n_mode    = p_mode;
                        n_count   = '0;
                        n_value   = '0;
                        push.res0 = val_res;
                        push.res0.last = !p_emit;
                        push.cnt  = p_emit ? 2'd2 : 2'd1;
                    end
                end
                default: begin
                    n_mode = sed_pkg::MODE_PLAIN;
                end
            endcase
        end

        if (!i_accept) begin
            n_mode   = r_mode;
            n_count  = r_count;
            n_value  = r_value;
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sed_pkg::MODE_PLAIN;
            r_count <= '0;
            r_value <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_value <= n_value;
        end
    end

`ifndef SYNTH
    a_plain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sed_pkg::MODE_PLAIN || r_mode == sed_pkg::MODE_ESC)
            |-> (r_count == '0 && r_value == '0))
        else $error("digit state not clear outside numeric escape");
    a_oct_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == sed_pkg::MODE_OCT
            |-> (r_count != '0 && r_count <= sed_pkg::COUNT_W'(MAX_OCTAL_DIGITS)))
        else $error("octal digit count out of range");
    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == sed_pkg::MODE_HEX
            |-> r_count <= sed_pkg::COUNT_W'(MAX_HEX_DIGITS))
        else $error("hex digit count out of range");
`endif

endmodule

// File: rtl/sed_out_queue.sv
`timescale 1ns / 1ps

module sed_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sed_pkg::t_push     i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output sed_pkg::t_out_item o_item
);

    // three-slot shift queue, head always in slot 0
    sed_pkg::t_out_item r_slot [0:2];
    sed_pkg::t_out_item n_slot [0:2];
    logic [1:0] r_count, n_count;
    logic       pop;
    logic [1:0] base;

    assign pop  = (r_count != 2'd0) && i_ready;
    assign base = r_count - {1'b0, pop};

    always_comb begin
        n_slot[0] = pop ? r_slot[1] : r_slot[0];
        n_slot[1] = pop ? r_slot[2] : r_slot[1];
        n_slot[2] = r_slot[2];
        if (i_push.cnt != 2'd0) begin
            case (base)
                2'd0: begin
                    n_slot[0] = i_push.res0;
                    n_slot[1] = i_push.res1;
                end
                2'd1: begin
                    n_slot[1] = i_push.res0;
                    n_slot[2] = i_push.res1;
                end
                default: begin
                    n_slot[2] = i_push.res0;
                end
            endcase
        end
        n_count = base + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
        r_slot[2] <= n_slot[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_space = r_count <= 2'd1;
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_slot[0];

`ifndef SYNTH
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_space)
        else $error("item pushed into full queue");
    a_pair_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 && i_push.cnt == 2'd2) |=> r_count == 2'd2)
        else $error("result pair not both queued");
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("head item changed while stalled");
`endif

endmodule

// File: rtl/string_escape_decoder_unit.sv
`timescale 1ns / 1ps

// String literal escape decoder.
// Input channel (i_in_valid / o_in_ready / i_in_item): one character of a
// string body per item, starting after the opening quote, or an end-of-input
// marker. Output channel (o_out_valid / i_out_ready / o_out_item): decoded
// characters, close, end-of-input and bad-escape results; each input item
// gives zero, one or two results, the final one flagged by last.
// Results are registered into the output queue as their input item is accepted.
// Throughput: one item per cycle while the receiver keeps up and no item
// gives two results (numeric escape ended by a plain character or a quote);
// such an item holds off the next one. The three-slot output queue sets the
// stall: o_in_ready comes from the queue's registered count and drops when
// two or more results are waiting.
// When the receiver stalls, results collect in the queue and input is held
// off; nothing is dropped.
// Reset (synchronous, active low) returns the decoder to plain text and
// empties the queue.
module string_escape_decoder_unit #(
    parameter int MAX_OCTAL_DIGITS = 3,
    parameter int MAX_HEX_DIGITS   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sed_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sed_pkg::t_out_item o_out_item
);

    logic           accept;
    logic           space;
    sed_pkg::t_push push;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    sed_decode #(
        .MAX_OCTAL_DIGITS(MAX_OCTAL_DIGITS),
        .MAX_HEX_DIGITS  (MAX_HEX_DIGITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_push  (push)
    );

    sed_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_space(space),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_item (o_out_item)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int OCT_LIMIT   = 3;
    localparam int HEX_LIMIT   = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam logic [sed_pkg::CHAR_W-1:0] CH_X = 21'h78;
    localparam logic [sed_pkg::CHAR_W-1:0] CH_G = 21'h67;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    sed_pkg::t_in_item  in_item  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sed_pkg::t_out_item out_item;

    string_escape_decoder_unit #(
        .MAX_OCTAL_DIGITS(OCT_LIMIT),
        .MAX_HEX_DIGITS  (HEX_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // items waiting to be offered, and decoded results waiting to come out
    sed_pkg::t_in_item  pending_chars[$];
    sed_pkg::t_out_item decoded_q[$];

    int  items_in       = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  strings_built  = 0;
    bit  quiet          = 1'b0;
    bit  long_hold_done = 1'b0;
    int  tx_idle        = 0;
    int  rx_idle        = 0;
    int  rx_hold        = 0;
    int  stall_cycles   = 0;

    // decoder state as predicted
    sed_pkg::t_mode                 esc_mode  = sed_pkg::MODE_PLAIN;
    logic [sed_pkg::COUNT_W-1:0]    digit_cnt = '0;
    logic [sed_pkg::CHAR_W-1:0]     digit_acc = '0;

    sed_pkg::t_out_item step_res[2];
    int                 step_n;

    function void put_result(logic [sed_pkg::CHAR_W-1:0] ch, logic [1:0] k);
        step_res[step_n].out_char = ch;
        step_res[step_n].kind     = k;
        step_res[step_n].last     = 1'b0;
        step_n++;
    endfunction

    function void clear_decoder();
        esc_mode  = sed_pkg::MODE_PLAIN;
        digit_cnt = '0;
        digit_acc = '0;
    endfunction

    function void take_plain(logic [sed_pkg::CHAR_W-1:0] c);
        if (c == sed_pkg::CH_QUOTE) begin
            clear_decoder();
            put_result('0, sed_pkg::KIND_CLOSE);
        end else if (c == sed_pkg::CH_BSLASH) begin
            esc_mode  = sed_pkg::MODE_ESC;
            digit_cnt = '0;
            digit_acc = '0;
        end else begin
            esc_mode = sed_pkg::MODE_PLAIN;
            put_result(c, sed_pkg::KIND_CHAR);
        end
    endfunction

    function void decode_item(sed_pkg::t_in_item it);
        logic [sed_pkg::CHAR_W-1:0] c;
        int hv;
        c = it.char_code;
        step_n = 0;
        if (it.end_of_input) begin
            clear_decoder();
            put_result('0, sed_pkg::KIND_EOI);
        end else begin
            case (esc_mode)
                sed_pkg::MODE_PLAIN: take_plain(c);
                sed_pkg::MODE_ESC: begin
                    if (c == sed_pkg::CH_N) begin
                        esc_mode = sed_pkg::MODE_PLAIN;
                        put_result(sed_pkg::CODE_LF, sed_pkg::KIND_CHAR);
                    end else if (c == sed_pkg::CH_R) begin
                        esc_mode = sed_pkg::MODE_PLAIN;
                        put_result(sed_pkg::CODE_CR, sed_pkg::KIND_CHAR);
                    end else if (c == sed_pkg::CH_BSLASH || c == sed_pkg::CH_QUOTE
                                 || c == sed_pkg::CH_APOS) begin
                        esc_mode = sed_pkg::MODE_PLAIN;
                        put_result(c, sed_pkg::KIND_CHAR);
                    end else if (c == sed_pkg::CH_U) begin
                        esc_mode  = sed_pkg::MODE_HEX;
                        digit_cnt = '0;
                        digit_acc = '0;
                    end else if (c >= sed_pkg::CH_0 && c <= sed_pkg::CH_7) begin
                        esc_mode  = sed_pkg::MODE_OCT;
                        digit_cnt = sed_pkg::COUNT_W'(1);
                        digit_acc = c - sed_pkg::CH_0;
                    end else begin
                        clear_decoder();
                        put_result('0, sed_pkg::KIND_BAD);
                    end
                end
                sed_pkg::MODE_OCT: begin
                    if (c >= sed_pkg::CH_0 && c <= sed_pkg::CH_7 && digit_cnt < OCT_LIMIT) begin
                        digit_acc = (digit_acc << 3) | (c - sed_pkg::CH_0);
                        digit_cnt = digit_cnt + 1'b1;
                    end else begin
                        put_result(digit_acc, sed_pkg::KIND_CHAR);
                        digit_cnt = '0;
                        digit_acc = '0;
                        take_plain(c);
                    end
                end
                default: begin
                    if (c >= sed_pkg::CH_0 && c <= sed_pkg::CH_9)
                        hv = int'(c - sed_pkg::CH_0);
                    else if (c >= sed_pkg::CH_LA && c <= sed_pkg::CH_LF_HEX)
                        hv = int'(c - sed_pkg::CH_LA) + 10;
                    else if (c >= sed_pkg::CH_UA && c <= sed_pkg::CH_UF)
                        hv = int'(c - sed_pkg::CH_UA) + 10;
                    else hv = -1;
                    if (hv >= 0 && digit_cnt < HEX_LIMIT) begin
                        digit_acc = (digit_acc << 4) | hv[sed_pkg::CHAR_W-1:0];
                        digit_cnt = digit_cnt + 1'b1;
                    end else if (digit_cnt == 0) begin
                        clear_decoder();
                        put_result('0, sed_pkg::KIND_BAD);
                    end else begin
                        put_result(digit_acc, sed_pkg::KIND_CHAR);
                        digit_cnt = '0;
                        digit_acc = '0;
                        take_plain(c);
                    end
                end
            endcase
        end
        if (step_n > 0) step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("tb_top: mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_seen, what, got, want);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function void queue_char(logic [sed_pkg::CHAR_W-1:0] c, logic eoi);
        sed_pkg::t_in_item it;
        it.char_code    = c;
        it.end_of_input = eoi;
        pending_chars.push_back(it);
    endfunction

    function logic [sed_pkg::CHAR_W-1:0] pick_plain();
        logic [sed_pkg::CHAR_W-1:0] c;
        do begin
            if ($urandom_range(0, 1)) c = sed_pkg::CHAR_W'($urandom_range(0, 1114111));
            else c = sed_pkg::CHAR_W'($urandom_range(32, 126));
        end while (c == sed_pkg::CH_QUOTE || c == sed_pkg::CH_BSLASH);
        return c;
    endfunction

    function logic [sed_pkg::CHAR_W-1:0] pick_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return sed_pkg::CH_0 + sed_pkg::CHAR_W'(v);
        if ($urandom_range(0, 1)) return sed_pkg::CH_LA + sed_pkg::CHAR_W'(v - 10);
        return sed_pkg::CH_UA + sed_pkg::CHAR_W'(v - 10);
    endfunction

    function logic [sed_pkg::CHAR_W-1:0] any_char();
        case ($urandom_range(0, 3))
            0: return sed_pkg::CHAR_W'($urandom_range(0, 1114111));
            1: return sed_pkg::CHAR_W'($urandom_range(32, 126));
            2: begin
                case ($urandom_range(0, 7))
                    0: return sed_pkg::CH_QUOTE;
                    1: return sed_pkg::CH_BSLASH;
                    2: return sed_pkg::CH_APOS;
                    3: return sed_pkg::CH_N;
                    4: return sed_pkg::CH_R;
                    5: return sed_pkg::CH_U;
                    6: return sed_pkg::CH_0 + sed_pkg::CHAR_W'($urandom_range(0, 7));
                    default: return CH_X;
                endcase
            end
            default: return pick_hex();
        endcase
    endfunction

    // one string body with random content, mostly closed by a quote
    task automatic add_string_body();
        int segs;
        int nd;
        int r;
        segs = $urandom_range(0, 8);
        repeat (segs) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: queue_char(pick_plain(), 1'b0);
                4: begin
                    queue_char(sed_pkg::CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 4))
                        0: queue_char(sed_pkg::CH_N, 1'b0);
                        1: queue_char(sed_pkg::CH_R, 1'b0);
                        2: queue_char(sed_pkg::CH_BSLASH, 1'b0);
                        3: queue_char(sed_pkg::CH_QUOTE, 1'b0);
                        default: queue_char(sed_pkg::CH_APOS, 1'b0);
                    endcase
                end
                5: begin
                    queue_char(sed_pkg::CH_BSLASH, 1'b0);
                    nd = $urandom_range(1, OCT_LIMIT + 1);
                    repeat (nd)
                        queue_char(sed_pkg::CH_0 + sed_pkg::CHAR_W'($urandom_range(0, 7)),
                                   1'b0);
                end
                6: begin
                    queue_char(sed_pkg::CH_BSLASH, 1'b0);
                    queue_char(sed_pkg::CH_U, 1'b0);
                    nd = $urandom_range(1, HEX_LIMIT + 1);
                    repeat (nd) queue_char(pick_hex(), 1'b0);
                end
                default: begin
                    // mostly bad escapes, the odd valid one by chance
                    queue_char(sed_pkg::CH_BSLASH, 1'b0);
                    if ($urandom_range(0, 1)) queue_char(sed_pkg::CH_U, 1'b0);
                    queue_char(any_char(), 1'b0);
                end
            endcase
        end
        r = $urandom_range(0, 19);
        if (r < 17) queue_char(sed_pkg::CH_QUOTE, 1'b0);
        else if (r < 19) queue_char(sed_pkg::CHAR_W'($urandom_range(0, 1114111)), 1'b1);
        strings_built++;
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 6))
            queue_char(any_char(), $urandom_range(0, 7) == 0);
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin : drv
        logic              nxt_valid;
        sed_pkg::t_in_item nxt_item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            tx_idle  = 0;
        end else begin
            nxt_valid = in_valid;
            nxt_item  = in_item;
            if (in_valid && in_ready) begin
                decode_item(in_item);
                items_in++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    tx_idle = $urandom_range(1, 15) - 1;
                end else if (pending_chars.size() > 0) begin
                    nxt_item  = pending_chars.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
            in_item  <= nxt_item;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : mon
        logic               nxt_ready;
        sed_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_idle   = 0;
            rx_hold   = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(out_item), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (out_item.out_char != want.out_char)
                        report_mismatch("out_char", 32'(out_item.out_char),
                                        32'(want.out_char));
                    if (out_item.kind != want.kind)
                        report_mismatch("kind", 32'(out_item.kind), 32'(want.kind));
                    if (out_item.last != want.last)
                        report_mismatch("last", 32'(out_item.last), 32'(want.last));
                end
                results_seen++;
            end
            // one long hold-off so the output queue fills and input backs up
            if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                nxt_ready = 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                nxt_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                rx_idle = $urandom_range(1, 15) - 1;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            out_ready <= nxt_ready;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // directed: extremes and each escape form
        queue_char(21'h10FFFF, 1'b0);
        // escaped backslash must not start another escape
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_N, 1'b0);
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_R, 1'b0);
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_APOS, 1'b0);
        // fourth octal digit is past the limit, comes out as plain text
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        repeat (4) queue_char(sed_pkg::CH_7, 1'b0);
        // hex escape ended by a backslash that opens a new escape
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_U, 1'b0);
        queue_char(sed_pkg::CH_UF, 1'b0);
        queue_char(sed_pkg::CH_LA, 1'b0);
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_N, 1'b0);
        // octal zero ended by the closing quote
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_0, 1'b0);
        queue_char(sed_pkg::CH_QUOTE, 1'b0);
        // u with no hex digit, then an unknown escape
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(sed_pkg::CH_U, 1'b0);
        queue_char(CH_G, 1'b0);
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(CH_X, 1'b0);
        // end of input in the middle of an escape
        queue_char(sed_pkg::CH_BSLASH, 1'b0);
        queue_char(21'h1FFFFF & 21'h10FFFF, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender holds back until every directed result is out
        wait_drained();

        @(negedge i_clk);
        while (pending_chars.size() < 600) begin
            if ($urandom_range(0, 9) == 0) add_noise();
            else add_string_body();
        end
        wait_drained();

        // final stretch at full rate on both sides
        @(negedge i_clk);
        quiet = 1'b1;
        while (pending_chars.size() < 100) add_string_body();
        wait_drained();

        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d items in, %0d results checked, %0d random strings",
                 items_in, results_seen, strings_built);
        $display("tb_top: covered escapes, digit limits, bad escapes, end of input, long stall");
        if (mismatches == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule
